// ===== rtl/tbim_pkg.sv =====
`default_nettype none

package tbim_pkg;

	localparam int MOMENTUM_BITS_DEF = 24;

endpackage

`default_nettype wire

// ===== rtl/tbim_in_if.sv =====
`default_nettype none

interface tbim_in_if
	import tbim_pkg::*;
#(
	parameter int N = MOMENTUM_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic signed [N-1:0] px_a;
	logic signed [N-1:0] py_a;
	logic signed [N-1:0] pz_a;
	logic        [N-2:0] mass_a;
	logic signed [N-1:0] px_b;
	logic signed [N-1:0] py_b;
	logic signed [N-1:0] pz_b;
	logic        [N-2:0] mass_b;

	modport source (
		output valid, px_a, py_a, pz_a, mass_a, px_b, py_b, pz_b, mass_b,
		input  ready
	);
	modport sink (
		input  valid, px_a, py_a, pz_a, mass_a, px_b, py_b, pz_b, mass_b,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/tbim_out_if.sv =====
`default_nettype none

interface tbim_out_if
	import tbim_pkg::*;
#(
	parameter int N = MOMENTUM_BITS_DEF
);
	logic         valid;
	logic         ready;
	logic [N-1:0] energy_a;
	logic [N-1:0] energy_b;
	logic [N:0]   pair_mass;
	logic         radicand_clamped;

	modport source (
		output valid, energy_a, energy_b, pair_mass, radicand_clamped,
		input  ready
	);
	modport sink (
		input  valid, energy_a, energy_b, pair_mass, radicand_clamped,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/tbim_sqrt_pipe.sv =====
`default_nettype none

module tbim_sqrt_pipe
	import tbim_pkg::*;
#(
	parameter int W      = MOMENTUM_BITS_DEF,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic [LANES-1:0][2*W-1:0]     rad,
	input  wire logic [SIDE_W-1:0]             side,
	output logic                               out_valid,
	output logic      [LANES-1:0][W-1:0]       root,
	output logic      [SIDE_W-1:0]             side_out
);
	localparam int RW = 2 * W;

	// One result bit per stage, most significant first; x holds n - root^2.
	logic              v_s    [W];
	logic [SIDE_W-1:0] side_s [W];
	logic [RW-1:0]     x_s    [W][LANES];
	logic [W-1:0]      r_s    [W][LANES];

	for (genvar k = 0; k < W; k++) begin : g_stage
		localparam int B = W - 1 - k;
		logic              v_in;
		logic [SIDE_W-1:0] side_in;
		logic [RW-1:0]     x_in [LANES];
		logic [W-1:0]      r_in [LANES];

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign side_in = side;
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign x_in[l] = rad[l];
				assign r_in[l] = '0;
			end
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign side_in = side_s[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_l
				assign x_in[l] = x_s[k-1][l];
				assign r_in[l] = r_s[k-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [RW:0] t;
			logic        fit;

			assign t   = ({{(RW + 1 - W){1'b0}}, r_in[l]} << (B + 1))
			           + ((RW + 1)'(1) << (2 * B));
			assign fit = t <= {1'b0, x_in[l]};

			always_ff @(posedge clk) begin
				if (en) begin
					x_s[k][l] <= fit ? x_in[l] - t[RW-1:0] : x_in[l];
					r_s[k][l] <= fit ? (r_in[l] | (W'(1) << B)) : r_in[l];
				end
			end
		end
	end

	assign out_valid = v_s[W-1];
	assign side_out  = side_s[W-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign root[l] = r_s[W-1][l];
	end

endmodule

`default_nettype wire

// ===== rtl/two_body_invariant_mass_unit.sv =====
`default_nettype none

// Two-body invariant mass. Each input word holds the momenta and rest masses of two
// particles; each output word gives floor(sqrt(m^2+|p|^2)) for both particles and
// floor(sqrt((Ea+Eb)^2-|pa+pb|^2)), with radicand_clamped set and pair_mass zero when
// the floored energies make that radicand negative. The unit is fully pipelined and
// accepts one word every cycle while the output is not stalled. Its stages are two
// squaring stages, one stage per energy root bit, the energy-sum square and
// subtraction stages, and one stage per pair-mass root bit. A stall on the
// output holds the whole pipeline, and ready on the input follows it in the same cycle.
module two_body_invariant_mass_unit
	import tbim_pkg::*;
#(
	parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tbim_in_if.sink     items,
	tbim_out_if.source  results
);
	localparam int N = MOMENTUM_BITS;

	logic en;
	logic out_valid;

	assign en          = !out_valid || results.ready;
	assign items.ready = en;

	logic [N-1:0]      mag_in [8];
	logic signed [N:0] psum   [3];
	logic [N:0]        pmag   [3];

	always_comb begin
		mag_in[0] = items.px_a[N-1] ? N'(-items.px_a) : N'(items.px_a);
		mag_in[1] = items.py_a[N-1] ? N'(-items.py_a) : N'(items.py_a);
		mag_in[2] = items.pz_a[N-1] ? N'(-items.pz_a) : N'(items.pz_a);
		mag_in[3] = {1'b0, items.mass_a};
		mag_in[4] = items.px_b[N-1] ? N'(-items.px_b) : N'(items.px_b);
		mag_in[5] = items.py_b[N-1] ? N'(-items.py_b) : N'(items.py_b);
		mag_in[6] = items.pz_b[N-1] ? N'(-items.pz_b) : N'(items.pz_b);
		mag_in[7] = {1'b0, items.mass_b};
		psum[0] = $signed({items.px_a[N-1], items.px_a}) + $signed({items.px_b[N-1], items.px_b});
		psum[1] = $signed({items.py_a[N-1], items.py_a}) + $signed({items.py_b[N-1], items.py_b});
		psum[2] = $signed({items.pz_a[N-1], items.pz_a}) + $signed({items.pz_b[N-1], items.pz_b});
		for (int i = 0; i < 3; i++) begin
			pmag[i] = psum[i][N] ? (N + 1)'(-psum[i]) : (N + 1)'(psum[i]);
		end
	end

	logic             v_s1;
	logic [2*N-1:0]   sq_s1  [8];
	logic [N:0]       pmag_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				sq_s1[i] <= mag_in[i] * mag_in[i];
			end
			for (int i = 0; i < 3; i++) begin
				pmag_s1[i] <= pmag[i];
			end
		end
	end

	logic                    v_s2;
	logic [1:0][2*N-1:0]     rad_s2;
	logic [2*N+1:0]          psq_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s2[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2] + sq_s1[3];
			rad_s2[1] <= sq_s1[4] + sq_s1[5] + sq_s1[6] + sq_s1[7];
			for (int i = 0; i < 3; i++) begin
				psq_s2[i] <= pmag_s1[i] * pmag_s1[i];
			end
		end
	end

	logic [2*N+1:0]     ptot;
	logic               e_valid;
	logic [1:0][N-1:0]  e_root;
	logic [2*N+1:0]     ptot_e;

	assign ptot = psq_s2[0] + psq_s2[1] + psq_s2[2];

	tbim_sqrt_pipe #(
		.W      (N),
		.LANES  (2),
		.SIDE_W (2 * N + 2)
	) u_energy_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.rad       (rad_s2),
		.side      (ptot),
		.out_valid (e_valid),
		.root      (e_root),
		.side_out  (ptot_e)
	);

	logic [N:0]     esum;
	logic           v_s3;
	logic [N-1:0]   ea_s3;
	logic [N-1:0]   eb_s3;
	logic [2*N+1:0] ptot_s3;
	logic [2*N+1:0] etot_s3;

	assign esum = {1'b0, e_root[0]} + {1'b0, e_root[1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= e_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ea_s3   <= e_root[0];
			eb_s3   <= e_root[1];
			ptot_s3 <= ptot_e;
			etot_s3 <= esum * esum;
		end
	end

	logic                v_s4;
	logic [N-1:0]        ea_s4;
	logic [N-1:0]        eb_s4;
	logic                clamp_s4;
	logic [0:0][2*N+1:0] rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ea_s4     <= ea_s3;
			eb_s4     <= eb_s3;
			clamp_s4  <= ptot_s3 > etot_s3;
			rad_s4[0] <= (ptot_s3 > etot_s3) ? '0 : etot_s3 - ptot_s3;
		end
	end

	logic [0:0][N:0] m_root;
	logic [2*N:0]    m_side;

	tbim_sqrt_pipe #(
		.W      (N + 1),
		.LANES  (1),
		.SIDE_W (2 * N + 1)
	) u_mass_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.rad       (rad_s4),
		.side      ({ea_s4, eb_s4, clamp_s4}),
		.out_valid (out_valid),
		.root      (m_root),
		.side_out  (m_side)
	);

	assign results.valid            = out_valid;
	assign results.pair_mass        = m_root[0];
	assign results.energy_a         = m_side[2*N:N+1];
	assign results.energy_b         = m_side[N:1];
	assign results.radicand_clamped = m_side[0];

endmodule

`default_nettype wire

// ===== rtl/tbim_checker.sv =====
`default_nettype none

module tbim_checker
	import tbim_pkg::*;
#(
	parameter int N = MOMENTUM_BITS_DEF
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [N-1:0] energy_a,
	input wire logic [N-1:0] energy_b,
	input wire logic [N:0]   pair_mass,
	input wire logic         radicand_clamped
);
	logic [N:0] esum;

	assign esum = {1'b0, energy_a} + {1'b0, energy_b};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_mass))
		else $error("output word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow the pipeline stall");

	a_clamp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && radicand_clamped |-> pair_mass == '0)
		else $error("clamped radicand with nonzero pair mass");

	a_mass_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pair_mass <= esum)
		else $error("pair mass exceeds the summed energies");

endmodule

bind two_body_invariant_mass_unit tbim_checker #(
	.N (MOMENTUM_BITS)
) u_tbim_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (items.valid),
	.in_ready         (items.ready),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.energy_a         (results.energy_a),
	.energy_b         (results.energy_b),
	.pair_mass        (results.pair_mass),
	.radicand_clamped (results.radicand_clamped)
);

`default_nettype wire
